[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, off while reset is held.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/asstd_pkg.sv]
// Constants and codes of the ADC scan sequencer with touch detection.
package asstd_pkg;

  localparam int MAX_SLOTS = 8;
  localparam int SLOT_W    = 3;
  localparam int SAMPLE_W  = 12;
  localparam int CODE_W    = 8;
  localparam int COUNT_W   = 8;
  localparam int LEN_W     = 4;
  localparam int THR_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_START  = 2'd1;
  localparam logic [1:0] ACT_CONV   = 2'd2;
  localparam logic [1:0] ACT_REWIND = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd2;

endpackage

[hdl/adc_scan_sequencer_touch_detect.sv]
// ADC scan sequencer: slot tables in synchronous RAM, touch compare, result register.
//
//   channel | handshake              | payload
//   in_     | in_valid / in_ready    | action, slot_index, channel_code, baseline,
//           |                        | sample_count, sample
//   out_    | out_valid / out_ready  | done_slot, raw_value, touched, sample_valid,
//           |                        | pass_done, start_next, next_channel
//   cfg_    | cfg_we                 | cfg_index, cfg_wdata
//
// One item per cycle while in_ready is high. A result is held first in the read stage,
// with the table RAM read, then in the output register. Position and pending count are
// flops updated on accept, so the next item sees them at once. rst_n is synchronous and
// clears control state; the tables are undefined until written. in_ready drops only
// when both the read stage and the output register hold results and out_ready is low.
module adc_scan_sequencer_touch_detect (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_action,
  input  logic [asstd_pkg::SLOT_W-1:0]   in_slot_index,
  input  logic [asstd_pkg::CODE_W-1:0]   in_channel_code,
  input  logic [asstd_pkg::SAMPLE_W-1:0] in_baseline,
  input  logic [asstd_pkg::COUNT_W-1:0]  in_sample_count,
  input  logic [asstd_pkg::SAMPLE_W-1:0] in_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [asstd_pkg::SLOT_W-1:0]   out_done_slot,
  output logic [asstd_pkg::SAMPLE_W-1:0] out_raw_value,
  output logic                           out_touched,
  output logic                           out_sample_valid,
  output logic                           out_pass_done,
  output logic                           out_start_next,
  output logic [asstd_pkg::CODE_W-1:0]   out_next_channel,
  input  logic                           cfg_we,
  input  logic [asstd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [asstd_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  localparam int SW = asstd_pkg::SLOT_W;
  localparam int DW = asstd_pkg::SAMPLE_W;
  localparam int CW = asstd_pkg::CODE_W;
  localparam int NW = asstd_pkg::COUNT_W;
  localparam int LW = asstd_pkg::LEN_W;
  localparam int TW = asstd_pkg::THR_W;

  logic [CW-1:0] sched_mem [asstd_pkg::MAX_SLOTS];
  logic [DW-1:0] base_mem  [asstd_pkg::MAX_SLOTS];

  logic [LW-1:0] len_r;
  logic [TW-1:0] thr_r;
  logic          mode_r;

  logic [SW-1:0] pos_r, pos_nxt;
  logic [NW-1:0] pend_r, pend_nxt;

  logic          s1_v_r, s1_v_nxt;
  logic [SW-1:0] s1_slot_r;
  logic [DW-1:0] s1_raw_r;
  logic          s1_tch_en_r;
  logic          s1_sv_r;
  logic          s1_wrap_r;
  logic          s1_sn_r;
  logic [CW-1:0] sched_rd_r;
  logic [DW-1:0] base_rd_r;

  logic          out_v_r, out_v_nxt;
  logic [SW-1:0] out_slot_r;
  logic [DW-1:0] out_raw_r;
  logic          out_tch_r;
  logic          out_sv_r;
  logic          out_wrap_r;
  logic          out_sn_r;
  logic [CW-1:0] out_code_r;

  logic          accept;
  logic          s1_move;
  logic          mem_we;
  logic          has_res;
  logic [SW-1:0] sched_addr;
  logic [LW-1:0] eff_len;
  logic [LW-1:0] pos_inc;
  logic          wrap;
  logic [SW-1:0] pos_adv;
  logic [NW-1:0] pend_dec;
  logic [SW-1:0] res_slot;
  logic [DW-1:0] res_raw;
  logic          res_tch_en;
  logic          res_sv;
  logic          res_wrap;
  logic          res_sn;

  logic signed [DW:0]   diff;
  logic signed [TW:0]   diff_x;
  logic signed [TW:0]   thr_x;
  logic                 touch_hit;

  assign s1_move  = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_move;
  assign accept   = in_valid && in_ready;

  always_comb begin
    eff_len = len_r;
    if (len_r == '0) begin
      eff_len = LW'(1);
    end else if (len_r > LW'(asstd_pkg::MAX_SLOTS)) begin
      eff_len = LW'(asstd_pkg::MAX_SLOTS);
    end
    pos_inc  = {{(LW-SW){1'b0}}, pos_r} + LW'(1);
    wrap     = (pos_inc >= eff_len);
    pos_adv  = wrap ? '0 : pos_inc[SW-1:0];
    pend_dec = pend_r - NW'(1);
  end

  always_comb begin
    pos_nxt    = pos_r;
    pend_nxt   = pend_r;
    mem_we     = 1'b0;
    has_res    = 1'b0;
    sched_addr = pos_r;
    res_slot   = '0;
    res_raw    = '0;
    res_tch_en = 1'b0;
    res_sv     = 1'b0;
    res_wrap   = 1'b0;
    res_sn     = 1'b0;
    unique case (in_action)
      asstd_pkg::ACT_WRITE: begin
        mem_we = 1'b1;
      end
      asstd_pkg::ACT_START: begin
        pend_nxt = in_sample_count;
        has_res  = 1'b1;
        res_sn   = (in_sample_count != '0);
      end
      asstd_pkg::ACT_CONV: begin
        if (pend_r != '0) begin
          has_res    = 1'b1;
          res_sv     = 1'b1;
          res_slot   = pos_r;
          res_raw    = in_sample;
          res_tch_en = mode_r;
          res_wrap   = wrap;
          pos_nxt    = pos_adv;
          pend_nxt   = pend_dec;
          res_sn     = (pend_dec != '0);
          sched_addr = pos_adv;
        end
      end
      asstd_pkg::ACT_REWIND: begin
        pos_nxt = '0;
      end
      default: begin
        pos_nxt = pos_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && mem_we) begin
      sched_mem[in_slot_index] <= in_channel_code;
      base_mem[in_slot_index]  <= in_baseline;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_res) begin
      sched_rd_r <= sched_mem[sched_addr];
      base_rd_r  <= base_mem[pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= LW'(1);
      thr_r  <= '0;
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        asstd_pkg::CFG_LENGTH:    len_r  <= cfg_wdata[LW-1:0];
        asstd_pkg::CFG_THRESHOLD: thr_r  <= cfg_wdata[TW-1:0];
        asstd_pkg::CFG_MODE:      mode_r <= cfg_wdata[0];
        default: begin
          mode_r <= mode_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      pend_r <= '0;
    end else if (accept) begin
      pos_r  <= pos_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept && has_res) begin
      s1_v_nxt = 1'b1;
    end else if (s1_move) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (s1_move) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_res) begin
      s1_slot_r   <= res_slot;
      s1_raw_r    <= res_raw;
      s1_tch_en_r <= res_tch_en;
      s1_sv_r     <= res_sv;
      s1_wrap_r   <= res_wrap;
      s1_sn_r     <= res_sn;
    end
  end

  always_comb begin
    diff      = $signed({1'b0, base_rd_r}) - $signed({1'b0, s1_raw_r});
    diff_x    = $signed({{(TW-DW){diff[DW]}}, diff});
    thr_x     = $signed({thr_r[TW-1], thr_r});
    touch_hit = s1_tch_en_r && (diff_x > thr_x);
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_slot_r <= s1_slot_r;
      out_raw_r  <= s1_raw_r;
      out_tch_r  <= touch_hit;
      out_sv_r   <= s1_sv_r;
      out_wrap_r <= s1_wrap_r;
      out_sn_r   <= s1_sn_r;
      out_code_r <= sched_rd_r;
    end
  end

  assign out_valid        = out_v_r;
  assign out_done_slot    = out_slot_r;
  assign out_raw_value    = out_raw_r;
  assign out_touched      = out_tch_r;
  assign out_sample_valid = out_sv_r;
  assign out_pass_done    = out_wrap_r;
  assign out_start_next   = out_sn_r;
  assign out_next_channel = out_code_r;

endmodule

[hdl/asstd_checker.sv]
// Port-level checker for the scan sequencer, bound to the top level.
`include "assert_macros.svh"

module asstd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [1:0]                      in_action,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [asstd_pkg::SLOT_W-1:0]    out_done_slot,
  input logic [asstd_pkg::SAMPLE_W-1:0]  out_raw_value,
  input logic                            out_touched,
  input logic                            out_sample_valid,
  input logic                            out_pass_done,
  input logic                            out_start_next,
  input logic [asstd_pkg::CODE_W-1:0]    out_next_channel
);

  logic [asstd_pkg::SLOT_W+asstd_pkg::SAMPLE_W+asstd_pkg::CODE_W+4:0] out_bus;
  logic                                                                start_idle;

  assign out_bus    = {out_done_slot, out_raw_value, out_touched, out_sample_valid,
                       out_pass_done, out_start_next, out_next_channel};
  assign start_idle = in_valid && in_ready && (in_action == asstd_pkg::ACT_START) && !out_valid;

  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_bus), "result changed while stalled")
  `ASSERT_ALWAYS(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty output")
  `ASSERT_NEXT(a_start_result, start_idle ##1 out_ready, out_valid, "start item gave no result")
  `ASSERT_ALWAYS(a_flags_need_sample, out_valid && (out_touched || out_pass_done) |-> out_sample_valid, "touch or pass flag without sample")

endmodule

bind adc_scan_sequencer_touch_detect asstd_checker u_asstd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_action        (in_action),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_done_slot    (out_done_slot),
  .out_raw_value    (out_raw_value),
  .out_touched      (out_touched),
  .out_sample_valid (out_sample_valid),
  .out_pass_done    (out_pass_done),
  .out_start_next   (out_start_next),
  .out_next_channel (out_next_channel)
);
